### hdl/udpfb_pkg.sv
`default_nettype none

package udpfb_pkg;

  // Operation codes carried on the input tuser.
  localparam logic [1:0] OP_HEADER  = 2'd0;
  localparam logic [1:0] OP_START   = 2'd1;
  localparam logic [1:0] OP_PAYLOAD = 2'd2;
  localparam logic [1:0] OP_SEND    = 2'd3;

  // Kinds of work handed from the front to the back.
  localparam logic [1:0] K_HDR  = 2'd0;
  localparam logic [1:0] K_PAY  = 2'd1;
  localparam logic [1:0] K_OVF  = 2'd2;
  localparam logic [1:0] K_SEND = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_MAC  = 1'b0;
  localparam logic CFG_PORT = 1'b1;

  localparam int          TX_CAPACITY_DEF = 1536;
  localparam int          POS_BITS        = 12;
  localparam int          QUEUE_DEPTH     = 4;
  localparam int          HDR_LEN         = 42;
  localparam int          HDR_LAST        = HDR_LEN - 1;
  localparam int          SEND_LAST       = 7;
  localparam logic [15:0] PORT_RESET      = 16'd3865;

  // The IP header words are fixed apart from the slots patched at send time,
  // so their partial sum is a constant.
  localparam logic [17:0] HDR_SUM  = 18'h2C50F;
  // Pseudo-header seed of the UDP sum: protocol, two broadcast words, plus 2.
  localparam logic [18:0] UDP_SEED = 19'h20011;

  typedef struct packed {
    logic [1:0]          kind;
    logic [POS_BITS-1:0] pos;   // byte offset, or frame length for a send
    logic [7:0]          data;
    logic [15:0]         ipc;
    logic [15:0]         udc;
  } entry_t;

  // Ones'-complement fold to 16 bits, then complement. Two additions suffice
  // because the first sum never exceeds 17 bits.
  function automatic logic [15:0] fold_not(input logic [31:0] s);
    logic [16:0] t;
    logic [15:0] u;
    t = {1'b0, s[15:0]} + {1'b0, s[31:16]};
    u = t[15:0] + {15'b0, t[16]};
    return ~u;
  endfunction

  function automatic logic [7:0] hdr_byte(input logic [5:0] idx,
                                          input logic [47:0] mac,
                                          input logic [15:0] port);
    logic [7:0] b;
    b = 8'h00;
    case (idx) inside
      [6'd0:6'd5]:     b = 8'hFF;
      6'd6:            b = mac[47:40];
      6'd7:            b = mac[39:32];
      6'd8:            b = mac[31:24];
      6'd9:            b = mac[23:16];
      6'd10:           b = mac[15:8];
      6'd11:           b = mac[7:0];
      6'd12:           b = 8'h08;
      6'd14:           b = 8'h45;
      6'd20, 6'd22:    b = 8'h40;
      6'd23:           b = 8'h11;
      [6'd30:6'd33]:   b = 8'hFF;
      6'd34, 6'd36:    b = port[15:8];
      6'd35, 6'd37:    b = port[7:0];
      default:         b = 8'h00;
    endcase
    return b;
  endfunction

  // Base offset of each patched word in a send run.
  function automatic logic [5:0] send_off(input logic [1:0] k);
    logic [5:0] o;
    case (k)
      2'd0:    o = 6'd16;
      2'd1:    o = 6'd24;
      2'd2:    o = 6'd38;
      default: o = 6'd40;
    endcase
    return o;
  endfunction

endpackage

`default_nettype wire

### hdl/udpfb_queue.sv
`default_nettype none

module udpfb_queue
  import udpfb_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] head,
  output logic                  full,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/udpfb_front.sv
`default_nettype none

module udpfb_front
  import udpfb_pkg::*;
#(
  parameter int TX_CAPACITY = TX_CAPACITY_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  operation,
  input  wire logic [7:0]  data_byte,
  input  wire logic [15:0] udp_port,
  input  wire logic        q_full,
  output logic             push,
  output entry_t           push_entry
);

  localparam int POS_W = $clog2(TX_CAPACITY + 1);

  logic [POS_W-1:0] pos;
  logic [31:0]      rsum;
  logic [17:0]      hsum;
  logic [18:0]      ubase;
  logic             busy;

  // Send operands captured in the accept cycle, folded in the next one.
  logic [18:0]      sa_ip;
  logic [31:0]      sa_udp;
  logic [POS_W-1:0] len_s;

  logic             accept;
  logic             at_cap;
  logic [15:0]      l1;
  logic [15:0]      l2;
  logic [18:0]      ubase_next;
  logic [31:0]      weight;

  assign in_ready   = !busy && !q_full;
  assign accept     = in_valid && in_ready;
  assign at_cap     = (pos >= POS_W'(TX_CAPACITY));
  assign l1         = 16'(pos) - 16'd14;
  assign l2         = 16'(pos) - 16'd34;
  assign ubase_next = UDP_SEED + {2'b00, udp_port, 1'b0};
  assign weight     = pos[0] ? {24'b0, data_byte} : {16'b0, data_byte, 8'b0};

  always_comb begin
    push       = 1'b0;
    push_entry = '0;
    if (busy) begin
      push           = 1'b1;
      push_entry.kind = K_SEND;
      push_entry.pos  = POS_BITS'(len_s);
      push_entry.ipc  = fold_not(32'(sa_ip));
      push_entry.udc  = fold_not(sa_udp);
    end else if (accept) begin
      unique case (operation)
        OP_HEADER: begin
          push            = 1'b1;
          push_entry.kind = K_HDR;
        end
        OP_PAYLOAD: begin
          push = 1'b1;
          if (at_cap) begin
            push_entry.kind = K_OVF;
          end else begin
            push_entry.kind = K_PAY;
            push_entry.pos  = POS_BITS'(pos);
            push_entry.data = data_byte;
          end
        end
        OP_START, OP_SEND: begin
          push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      rsum  <= '0;
      hsum  <= '0;
      ubase <= '0;
      busy  <= 1'b0;
    end else if (busy) begin
      // The checksum words of the send just issued join the running sum.
      rsum <= rsum + 32'(push_entry.ipc) + 32'(push_entry.udc);
      busy <= 1'b0;
    end else if (accept) begin
      unique case (operation)
        OP_HEADER: begin
          hsum  <= HDR_SUM;
          ubase <= ubase_next;
          rsum  <= 32'(ubase_next);
          pos   <= POS_W'(HDR_LEN);
        end
        OP_START: begin
          rsum <= 32'(ubase);
          pos  <= POS_W'(HDR_LEN);
        end
        OP_PAYLOAD: begin
          if (!at_cap) begin
            rsum <= rsum + weight;
            pos  <= pos + 1'b1;
          end
        end
        OP_SEND: begin
          rsum <= rsum + 32'(l1) + 32'(l2);
          pos  <= POS_W'(HDR_LEN);
          busy <= 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && operation == OP_SEND) begin
      sa_ip  <= 19'(hsum) + 19'(l1);
      sa_udp <= rsum + {15'b0, l2, 1'b0};
      len_s  <= pos;
    end
  end

`ifndef SYNTHESIS
  a_send_busy: assert property (@(posedge clk) disable iff (rst)
    accept && operation == OP_SEND |=> busy)
    else $error("send accept did not start the fold cycle");
  a_busy_one: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("fold cycle lasted more than one cycle");
  a_pos_cap: assert property (@(posedge clk) disable iff (rst)
    pos <= POS_W'(TX_CAPACITY))
    else $error("write position beyond capacity");
`endif

endmodule

`default_nettype wire

### hdl/udpfb_back.sv
`default_nettype none

module udpfb_back
  import udpfb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_empty,
  input  wire entry_t      head,
  output logic             pop,
  input  wire logic [47:0] mac_address,
  input  wire logic [15:0] udp_port,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,
  output logic             m_axis_tlast,
  output logic             m_axis_tuser
);

  logic [5:0]  idx;
  logic        load;
  logic        fin;
  logic [10:0] off;
  logic [7:0]  bval;
  logic        lst;
  logic [10:0] flen;
  logic        ovf;
  logic [15:0] l1;
  logic [15:0] l2;
  logic [15:0] word;
  logic [5:0]  base;

  assign load = !q_empty && (!m_axis_tvalid || m_axis_tready);
  assign pop  = load && fin;
  assign l1   = 16'(head.pos) - 16'd14;
  assign l2   = 16'(head.pos) - 16'd34;
  assign base = send_off(idx[2:1]);

  always_comb begin
    case (idx[2:1])
      2'd0:    word = l1;
      2'd1:    word = head.ipc;
      2'd2:    word = l2;
      default: word = head.udc;
    endcase
  end

  always_comb begin
    off  = '0;
    bval = '0;
    lst  = 1'b0;
    flen = '0;
    ovf  = 1'b0;
    fin  = 1'b1;
    unique case (head.kind)
      K_HDR: begin
        off  = 11'(idx);
        bval = hdr_byte(idx, mac_address, udp_port);
        lst  = (idx == 6'(HDR_LAST));
        fin  = lst;
      end
      K_PAY: begin
        off  = 11'(head.pos);
        bval = head.data;
      end
      K_OVF: begin
        ovf = 1'b1;
      end
      K_SEND: begin
        off  = 11'({base[5:1], idx[0]});
        bval = idx[0] ? word[7:0] : word[15:8];
        lst  = (idx == 6'(SEND_LAST));
        flen = lst ? 11'(head.pos) : '0;
        fin  = lst;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      idx           <= '0;
    end else begin
      if (load) begin
        m_axis_tvalid <= 1'b1;
        idx           <= fin ? '0 : idx + 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_axis_tdata <= {2'b00, flen, bval, off};
      m_axis_tlast <= lst;
      m_axis_tuser <= ovf;
    end
  end

`ifndef SYNTHESIS
  a_ovf_clean: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0 && !m_axis_tlast)
    else $error("overflow item carries data");
  a_flen_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[29:19] == '0)
    else $error("frame length shown on an item that is not last");
  a_send_idx: assert property (@(posedge clk) disable iff (rst)
    !q_empty && head.kind == K_SEND |-> idx <= 6'(SEND_LAST))
    else $error("send run index out of range");
`endif

endmodule

`default_nettype wire

### hdl/udp_broadcast_frame_builder.sv
`default_nettype none
// A payload item reaches the output through the queue and the output register, as does
// the first item of a header run; a send's operands are first captured in registers.
// Input takes one item per cycle while the queue is not full, but a send holds it off
// while both checksums are folded; output runs one item per cycle while the receiver
// is ready (42 per header, 8 per send); a four-entry queue lets input run ahead of it.
// Reset (synchronous): clears position, sums, queue and output valid; port reads 3865.

module udp_broadcast_frame_builder
  import udpfb_pkg::*;
#(
  parameter int TX_CAPACITY = TX_CAPACITY_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [47:0] cfg_data,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  wire logic [1:0]  s_axis_tuser,  // [1:0] operation
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // [10:0] buf_offset, [18:11] byte_value,
                                          // [29:19] frame_length, [31:30] zero
  output logic             m_axis_tlast,
  output logic             m_axis_tuser   // [0] overflow
);

  logic [47:0] mac_address;
  logic [15:0] udp_port;
  logic        push;
  entry_t      push_entry;
  entry_t      head;
  logic        pop;
  logic        q_full;
  logic        q_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mac_address <= '0;
      udp_port    <= PORT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MAC:  mac_address <= cfg_data;
        CFG_PORT: udp_port    <= cfg_data[15:0];
      endcase
    end
  end

  udpfb_front #(
    .TX_CAPACITY(TX_CAPACITY)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .operation  (s_axis_tuser),
    .data_byte  (s_axis_tdata),
    .udp_port   (udp_port),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  udpfb_queue #(
    .WIDTH($bits(entry_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (push_entry),
    .pop   (pop),
    .head  (head),
    .full  (q_full),
    .empty (q_empty)
  );

  udpfb_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .head          (head),
    .pop           (pop),
    .mac_address   (mac_address),
    .udp_port      (udp_port),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

`default_nettype wire

### tb/sv/udp_broadcast_frame_builder_tb.sv
`default_nettype none

module udp_broadcast_frame_builder_tb;
  import udpfb_pkg::*;

  localparam int          CAPACITY    = TX_CAPACITY_DEF;
  localparam int          HEADER_LEN  = 42;
  localparam logic [31:0] PSEUDO_SEED = 32'h11 + 32'hFFFF + 32'hFFFF + 32'd2;
  localparam int          SETTLE      = 8;
  localparam int          DRAIN       = 20;
  localparam int          LONG_HOLD   = 200;
  localparam int unsigned CYCLE_LIMIT = 5000000;
  localparam int          DIR_ROWS    = 23;

  typedef struct packed {
    logic [10:0] offset;
    logic [7:0]  value;
    logic        last;
    logic [10:0] length;
    logic        dropped;
  } frame_write_t;

  // A pinned row carries the offset and byte of its first write, typed in.
  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  data;
    logic        pinned;
    logic [10:0] offset;
    logic [7:0]  value;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [47:0] cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  udp_broadcast_frame_builder u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  stim_row_t directed_rows [DIR_ROWS] = '{
    '{OP_PAYLOAD, 8'hFF, 1'b1, 11'd0,  8'hFF},
    '{OP_PAYLOAD, 8'h00, 1'b1, 11'd1,  8'h00},
    '{OP_SEND,    8'h00, 1'b1, 11'd16, 8'hFF},
    '{OP_HEADER,  8'h5A, 1'b1, 11'd0,  8'hFF},
    '{OP_PAYLOAD, 8'h00, 1'b0, 11'd0,  8'h00},
    '{OP_PAYLOAD, 8'hFF, 1'b0, 11'd0,  8'h00},
    '{OP_PAYLOAD, 8'h80, 1'b0, 11'd0,  8'h00},
    '{OP_PAYLOAD, 8'h01, 1'b0, 11'd0,  8'h00},
    '{OP_PAYLOAD, 8'h55, 1'b0, 11'd0,  8'h00},
    '{OP_SEND,    8'hFF, 1'b0, 11'd0,  8'h00},
    '{OP_SEND,    8'h00, 1'b0, 11'd0,  8'h00},
    '{OP_START,   8'h3C, 1'b0, 11'd0,  8'h00},
    '{OP_SEND,    8'h00, 1'b1, 11'd16, 8'h00},
    '{OP_START,   8'h00, 1'b0, 11'd0,  8'h00},
    '{OP_PAYLOAD, 8'hAA, 1'b0, 11'd0,  8'h00},
    '{OP_SEND,    8'h00, 1'b0, 11'd0,  8'h00},
    '{OP_PAYLOAD, 8'h7F, 1'b0, 11'd0,  8'h00},
    '{OP_START,   8'hFF, 1'b0, 11'd0,  8'h00},
    '{OP_PAYLOAD, 8'hFE, 1'b0, 11'd0,  8'h00},
    '{OP_PAYLOAD, 8'h00, 1'b0, 11'd0,  8'h00},
    '{OP_HEADER,  8'h00, 1'b0, 11'd0,  8'h00},
    '{OP_PAYLOAD, 8'h11, 1'b0, 11'd0,  8'h00},
    '{OP_SEND,    8'h00, 1'b0, 11'd0,  8'h00}
  };

  frame_write_t expected_writes [$];
  logic [47:0]  mac_q;
  logic [15:0]  port_q;
  int           tx_pos;
  logic [31:0]  payload_sum;
  logic [31:0]  ip_hdr_sum;
  logic [31:0]  udp_hdr_sum;
  bit           quiet;
  bit           hold_request;
  int           mismatches = 0;
  int unsigned  cycles = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("udp_broadcast_frame_builder_tb failed");
      $finish;
    end
  end

  function automatic logic [31:0] byte_weight(input int pos, input logic [7:0] b);
    return (pos & 1) ? {24'd0, b} : {16'd0, b, 8'd0};
  endfunction

  function automatic logic [15:0] ones_fold_not(input logic [31:0] s);
    while (s[31:16] != 16'd0)
      s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
    return ~s[15:0];
  endfunction

  task automatic push_write(input int off, input logic [7:0] val, input logic fin,
                            input int len, input logic drop);
    expected_writes.push_back('{11'(off), val, fin, 11'(len), drop});
  endtask

  // Works out the buffer writes caused by one accepted item and advances the
  // predicted state.
  task automatic predict_writes(input logic [1:0] op, input logic [7:0] d, input int row);
    logic [7:0]  hb [0:HEADER_LEN-1];
    logic [15:0] words [0:3];
    int          offs [0:3];
    int          first;
    int          i;
    first = expected_writes.size();
    case (op)
      OP_HEADER: begin
        for (i = 0; i < HEADER_LEN; i++) hb[i] = 8'h00;
        for (i = 0; i < 6; i++) begin
          hb[i] = 8'hFF;
          hb[6 + i] = mac_q[47 - 8 * i -: 8];
        end
        hb[12] = 8'h08;
        hb[14] = 8'h45;
        hb[20] = 8'h40;
        hb[22] = 8'h40;
        hb[23] = 8'h11;
        for (i = 30; i < 34; i++) hb[i] = 8'hFF;
        hb[34] = port_q[15:8];
        hb[35] = port_q[7:0];
        hb[36] = port_q[15:8];
        hb[37] = port_q[7:0];
        ip_hdr_sum = '0;
        udp_hdr_sum = PSEUDO_SEED;
        for (i = 0; i < HEADER_LEN; i++) begin
          if (i >= 14 && i < 34) ip_hdr_sum += byte_weight(i, hb[i]);
          else if (i >= 34) udp_hdr_sum += byte_weight(i, hb[i]);
          push_write(i, hb[i], i == HEADER_LEN - 1, 0, 1'b0);
        end
        payload_sum = udp_hdr_sum;
        tx_pos = HEADER_LEN;
      end
      OP_START: begin
        tx_pos = HEADER_LEN;
        payload_sum = udp_hdr_sum;
      end
      OP_PAYLOAD: begin
        if (tx_pos >= CAPACITY) begin
          push_write(0, 8'h00, 1'b0, 0, 1'b1);
        end else begin
          payload_sum += byte_weight(tx_pos, d);
          push_write(tx_pos, d, 1'b0, 0, 1'b0);
          tx_pos++;
        end
      end
      default: begin
        // The lengths wrap to 16 bits when the frame is shorter than its headers.
        words[0] = 16'(tx_pos - 14);
        words[1] = ones_fold_not(ip_hdr_sum + {16'd0, words[0]});
        words[2] = 16'(tx_pos - 34);
        words[3] = ones_fold_not(payload_sum + 2 * {16'd0, words[2]});
        offs = '{16, 24, 38, 40};
        for (i = 0; i < 4; i++) begin
          push_write(offs[i], words[i][15:8], 1'b0, 0, 1'b0);
          push_write(offs[i] + 1, words[i][7:0], i == 3, (i == 3) ? tx_pos : 0, 1'b0);
          payload_sum += {16'd0, words[i]};
        end
        tx_pos = HEADER_LEN;
      end
    endcase
    if (row >= 0 && directed_rows[row].pinned) begin
      expected_writes[first].offset = directed_rows[row].offset;
      expected_writes[first].value = directed_rows[row].value;
    end
  endtask

  task automatic offer(input logic [1:0] op, input logic [7:0] d, input int row);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 7);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= d;
    do @(posedge clk); while (!s_axis_tready);
    predict_writes(op, d, row);
  endtask

  task automatic program_regs(input logic [47:0] mac, input logic [15:0] port_word);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_MAC;
    cfg_data <= mac;
    do @(posedge clk); while (!cfg_ready);
    mac_q = mac;
    // Upper bits of a port write are don't-care and get random values.
    cfg_index <= CFG_PORT;
    cfg_data <= {32'($urandom), port_word};
    do @(posedge clk); while (!cfg_ready);
    port_q = port_word;
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_writes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Mostly well-formed frames with random content, with some stray items mixed in.
  task automatic run_frames(input int target);
    int done;
    int n;
    done = 0;
    while (done < target) begin
      if ($urandom_range(0, 9) < 2) begin
        offer(2'($urandom_range(0, 3)), 8'($urandom), -1);
        done++;
      end else begin
        offer(($urandom_range(0, 3) == 0) ? OP_HEADER : OP_START, 8'($urandom), -1);
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 12);
        repeat (n) offer(OP_PAYLOAD, 8'($urandom), -1);
        offer(OP_SEND, 8'($urandom), -1);
        done += n + 2;
      end
    end
  endtask

  initial begin
    int stall;
    int hold;
    stall = 0;
    hold = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold = LONG_HOLD;
      end
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 7) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    frame_write_t got;
    frame_write_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      // tdata: [10:0] offset, [18:11] byte, [29:19] frame length.
      got = '{m_axis_tdata[10:0], m_axis_tdata[18:11], m_axis_tlast,
              m_axis_tdata[29:19], m_axis_tuser};
      if (expected_writes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected write: off=%0d byte=%02h last=%0b len=%0d ovf=%0b",
                   got.offset, got.value, got.last, got.length, got.dropped);
      end else begin
        want = expected_writes.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: want off=%0d byte=%02h last=%0b len=%0d ovf=%0b,",
                      " got off=%0d byte=%02h last=%0b len=%0d ovf=%0b"},
                     want.offset, want.value, want.last, want.length, want.dropped,
                     got.offset, got.value, got.last, got.length, got.dropped);
        end
      end
    end
  end

  initial begin
    int r;
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_MAC;
    cfg_data <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= OP_START;
    quiet = 1'b0;
    hold_request = 1'b0;
    mac_q = '0;
    port_q = PORT_RESET;
    tx_pos = 0;
    payload_sum = '0;
    ip_hdr_sum = '0;
    udp_hdr_sum = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset configuration first, including payload and send before any header.
    for (r = 0; r < DIR_ROWS; r++)
      offer(directed_rows[r].op, directed_rows[r].data, r);
    wait_idle();

    program_regs('1, '1);
    run_frames(70);
    wait_idle();

    program_regs('0, '0);
    hold_request = 1'b1;
    run_frames(70);
    wait_idle();

    // Fill the buffer to capacity, push a few bytes past it, then send.
    program_regs({16'($urandom), 32'($urandom)}, 16'($urandom));
    offer(OP_START, 8'($urandom), -1);
    while (tx_pos < CAPACITY) offer(OP_PAYLOAD, 8'($urandom), -1);
    repeat (3) offer(OP_PAYLOAD, 8'($urandom), -1);
    offer(OP_SEND, 8'($urandom), -1);
    run_frames(30);
    wait_idle();

    program_regs({16'($urandom), 32'($urandom)}, 16'($urandom));
    quiet = 1'b1;
    run_frames(60);

    s_axis_tvalid <= 1'b0;
    while (expected_writes.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (mismatches == 0)
      $display("udp_broadcast_frame_builder_tb passed");
    else
      $display("udp_broadcast_frame_builder_tb failed");
    $finish;
  end

endmodule

`default_nettype wire
